// ===== src/mstl_pkg.sv =====
// shared types and constants of the master-stack tile layout block
// used by mstl_div and master_stack_tile_layout; no dependencies
package mstl_pkg;

	// field widths
	localparam int DIM_W   = 12;  // screen dimension registers, frame_x
	localparam int COORD_W = 13;  // signed frame coordinates
	localparam int RATIO_W = 7;
	localparam int CNT_IN_W = 4;
	localparam int IDX_W   = 3;

	// layout constants in pixels
	localparam int OUTER_GAP  = 10;
	localparam int INNER_GAP  = 8;
	localparam int MIN_COLUMN = 100;
	localparam int PERCENT    = 100;

	// shared divider: dividend holds the stack height numerator (at most 4075 < 2**12)
	localparam int DIVD_W = 12;
	localparam int DIVS_W = 7;

	// master width: area width times ratio (4075 * 127 < 2**19), then times 1/100
	localparam int PROD_W      = 19;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 26;
	// ceil(2**26 / 100), exact floor division for any product below 2**19
	localparam logic [RECIP_W-1:0] RECIP_PERCENT = 20'd671089;

	localparam int MAX_WINDOWS_DEF = 8;

	// configuration register indexes
	localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_LAYOUT_MODE   = 2'd2;
	localparam logic [1:0] CFG_MASTER_RATIO  = 2'd3;

	// layout mode codes
	localparam logic MODE_MASTER_STACK = 1'b0;
	localparam logic MODE_MONOCLE      = 1'b1;

	// divider request and response
	typedef struct packed {
		logic              go;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== src/master_stack_tile_layout.sv =====
// master-stack / monocle tile layout: one frame per window, last frame flagged; the window
// count saturates to MAX_WINDOWS, and zero windows or an empty master-stack area give none
// monocle or single window: the sequencer goes straight from idle to emitting the frames
// master-stack: product, reciprocal scale by 1/100, clamp, then a divider pass, then emit
// frames leave back to back; busy stays high until the last frame is issued; no receiver stall
// arst_n clears control state and loads the configuration reset values
module master_stack_tile_layout
	import mstl_pkg::*;
#(
	parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// command side
	input  logic                       start,
	output logic                       busy,
	input  logic [CNT_IN_W-1:0]        num_windows,
	// configuration write port
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_addr,
	input  logic [DIM_W-1:0]           cfg_wdata,
	// result side
	output logic                       valid,
	output logic [IDX_W-1:0]           client_index,
	output logic [DIM_W-1:0]           frame_x,
	output logic signed [COORD_W-1:0]  frame_y,
	output logic signed [COORD_W-1:0]  frame_w,
	output logic signed [COORD_W-1:0]  frame_h,
	output logic                       last
);

	localparam int NW = $clog2(MAX_WINDOWS + 1);
	localparam int CW = (NW > CNT_IN_W) ? NW : CNT_IN_W;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MUL   = 6'b000010,
		ST_SCALE = 6'b000100,
		ST_CLAMP = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [DIM_W-1:0]   scr_w_q;
	logic [DIM_W-1:0]   scr_h_q;
	logic               mode_q;
	logic [RATIO_W-1:0] ratio_q;

	// per-transaction registers
	logic [NW-1:0]              n_q;
	logic [NW-1:0]              idx_q;
	logic [PROD_W-1:0]          prod_q;
	logic [COORD_W-1:0]         mw_raw_q;
	logic signed [COORD_W-1:0]  mw_q;
	logic signed [COORD_W-1:0]  each_q;
	logic signed [COORD_W-1:0]  y_q;
	logic                       neg_q;

	// result registers
	logic                       valid_q;
	logic                       last_q;
	logic [IDX_W-1:0]           idx_out_q;
	logic [DIM_W-1:0]           fx_q;
	logic signed [COORD_W-1:0]  fy_q;
	logic signed [COORD_W-1:0]  fw_q;
	logic signed [COORD_W-1:0]  fh_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                       accept;
	logic [NW-1:0]              n_sat;
	logic signed [COORD_W-1:0]  ww;
	logic signed [COORD_W-1:0]  wh;
	logic                       area_empty;
	logic [PROD_W-1:0]          product;
	logic [PROD_W+RECIP_W-1:0]  scaled;
	logic signed [COORD_W-1:0]  avail;
	logic [COORD_W-1:0]         avail_mag;
	logic [COORD_W-1:0]         mw_lo;
	logic signed [COORD_W-1:0]  mw_hi;
	logic signed [COORD_W-1:0]  mw_clamped;
	logic signed [COORD_W-1:0]  q_signed;
	logic                       full_area;
	logic                       is_last;
	logic signed [COORD_W-1:0]  fx;
	logic signed [COORD_W-1:0]  fy;
	logic signed [COORD_W-1:0]  fw;
	logic signed [COORD_W-1:0]  fh;

	mstl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// usable area inside the outer gap
	always_comb begin
		ww = $signed({1'b0, scr_w_q}) - COORD_W'(2 * OUTER_GAP);
		wh = $signed({1'b0, scr_h_q}) - COORD_W'(2 * OUTER_GAP);
		area_empty = ww[COORD_W-1] || (ww == '0) || wh[COORD_W-1] || (wh == '0);
	end

	// window count saturated to the parameter
	always_comb begin
		if (CW'(num_windows) > CW'(MAX_WINDOWS))
			n_sat = NW'(MAX_WINDOWS);
		else
			n_sat = NW'(num_windows);
	end

	// master width numerator, its scaling by 1/100 and the stack height numerator
	always_comb begin
		product   = PROD_W'(ww[DIM_W-1:0]) * PROD_W'(ratio_q);
		scaled    = (PROD_W + RECIP_W)'(prod_q) * (PROD_W + RECIP_W)'(RECIP_PERCENT);
		avail     = wh - (COORD_W'(n_q) - COORD_W'(2)) * COORD_W'(INNER_GAP);
		avail_mag = avail[COORD_W-1] ? COORD_W'(-avail) : COORD_W'(avail);
	end

	// divider request: stack height
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_CLAMP: begin
				div_req.go       = 1'b1;
				div_req.dividend = DIVD_W'(avail_mag);
				div_req.divisor  = DIVS_W'(n_q - 1'b1);
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	// master width clamps: at least the minimum column, then leave one for the stack
	always_comb begin
		mw_lo = (mw_raw_q < COORD_W'(MIN_COLUMN)) ? COORD_W'(MIN_COLUMN) : mw_raw_q;
		mw_hi = ww - COORD_W'(MIN_COLUMN);
		if ($signed({1'b0, mw_lo}) > (COORD_W + 1)'(mw_hi))
			mw_clamped = mw_hi;
		else
			mw_clamped = $signed(mw_lo);
		q_signed = COORD_W'(div_rsp.quotient);
	end

	// frame of the current window
	always_comb begin
		full_area = (mode_q == MODE_MONOCLE) || (n_q == NW'(1));
		is_last   = (idx_q == n_q - 1'b1);
		if (full_area) begin
			fx = COORD_W'(OUTER_GAP);
			fy = COORD_W'(OUTER_GAP);
			fw = ww;
			fh = wh;
		end else if (idx_q == '0) begin
			fx = COORD_W'(OUTER_GAP);
			fy = COORD_W'(OUTER_GAP);
			fw = mw_q;
			fh = wh;
		end else begin
			fx = COORD_W'(OUTER_GAP + INNER_GAP) + mw_q;
			fy = y_q;
			fw = ww - mw_q - COORD_W'(INNER_GAP);
			fh = is_last ? (COORD_W'(OUTER_GAP) + wh - y_q) : each_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (n_sat != '0)) begin
						if (mode_q == MODE_MONOCLE)
							state_q <= ST_EMIT;
						else if (area_empty)
							state_q <= ST_IDLE;
						else if (n_sat == NW'(1))
							state_q <= ST_EMIT;
						else
							state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					valid_q <= 1'b1;
					if (is_last)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-transaction datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q   <= n_sat;
			idx_q <= '0;
			y_q   <= COORD_W'(OUTER_GAP);
		end
		if (state_q == ST_MUL)
			prod_q <= product;
		if (state_q == ST_SCALE)
			mw_raw_q <= scaled[RECIP_SHIFT +: COORD_W];
		if (state_q == ST_CLAMP) begin
			mw_q  <= mw_clamped;
			neg_q <= avail[COORD_W-1];
		end
		if ((state_q == ST_DIV) && div_rsp.done)
			each_q <= neg_q ? -q_signed : q_signed;
		if (state_q == ST_EMIT) begin
			idx_q     <= idx_q + 1'b1;
			if (idx_q != '0)
				y_q <= fy + fh + COORD_W'(INNER_GAP);
			idx_out_q <= IDX_W'(idx_q);
			fx_q      <= fx[DIM_W-1:0];
			fy_q      <= fy;
			fw_q      <= fw;
			fh_q      <= fh;
			last_q    <= is_last;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= DIM_W'(640);
			scr_h_q <= DIM_W'(480);
			mode_q  <= MODE_MASTER_STACK;
			ratio_q <= RATIO_W'(50);
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_SCREEN_WIDTH:  scr_w_q <= cfg_wdata;
				CFG_SCREEN_HEIGHT: scr_h_q <= cfg_wdata;
				CFG_LAYOUT_MODE:   mode_q  <= cfg_wdata[0];
				CFG_MASTER_RATIO:  ratio_q <= cfg_wdata[RATIO_W-1:0];
				default: begin
					scr_w_q <= scr_w_q;
				end
			endcase
		end
	end

	assign valid        = valid_q;
	assign client_index = idx_out_q;
	assign frame_x      = fx_q;
	assign frame_y      = fy_q;
	assign frame_w      = fw_q;
	assign frame_h      = fh_q;
	assign last         = valid_q && last_q;

`ifndef ASSERT_OFF
	// a frame only leaves after an emit cycle
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(state_q == ST_EMIT))
		else $error("frame issued outside emit");

	// the last frame closes the transaction
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |=> !valid)
		else $error("frame follows last frame");

	// divider completes only while the sequencer waits on it
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider done while not waited on");

	// frames carry indexes below the window count
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (idx_q < n_q))
		else $error("window index out of range");
`endif

endmodule

// ===== src/mstl_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on mstl_pkg for widths and request/response types
module mstl_div
	import mstl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(DIVD_W);

	logic              active_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVD_W-1:0] quo_q;

	logic [DIVS_W:0]   shifted;
	logic [DIVS_W:0]   diff;

	// trial subtract of the next partial remainder
	always_comb begin
		shifted = {rem_q, quo_q[DIVD_W-1]};
		diff    = shifted - {1'b0, dvs_q};
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			step_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end else if (active_q) begin
				if (step_q == STEP_W'(DIVD_W - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// datapath: quotient shifts in where the dividend shifts out
	always_ff @(posedge clk) begin
		if (req.go) begin
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= req.dividend;
		end else if (active_q) begin
			if (!diff[DIVS_W]) begin
				rem_q <= diff[DIVS_W-1:0];
				quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIVS_W-1:0];
				quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
